/* design/dcmr_pkg.sv */
// Shared constants, item types and the secant scale table for the depth column ranger.
`timescale 1ns / 1ps
package dcmr_pkg;

    localparam int COLUMNS           = 512;
    localparam int FIELD_OF_VIEW_DEG = 70;

    localparam int CODE_W    = 8;
    localparam int COL_OUT_W = 9;
    localparam int RANGE_W   = 16;
    localparam int K_W       = 18;
    localparam int PROD_W    = K_W + CODE_W;
    localparam int FRAC_W    = 10;

    localparam int COL_W       = $clog2(COLUMNS);
    localparam int HALF_COLUMNS = COLUMNS / 2;
    localparam int ROM_DEPTH   = HALF_COLUMNS + 1;
    localparam int ROM_AW      = $clog2(ROM_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MIN_VALID_CODE = REG_IDX_W'(0);
    localparam logic [CODE_W-1:0]    MIN_VALID_RESET    = CODE_W'(6);
    localparam logic [CODE_W-1:0]    NO_RETURN_CODE     = CODE_W'(255);

    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned ROM_MAX     = 64'd262143;
    localparam longint unsigned SCALE_NUM   = 64'd46080000;
    localparam int              TAYLOR_TERMS = 12;

    typedef logic [K_W-1:0] sec_rom_t [ROM_DEPTH];

    typedef struct packed {
        logic [COL_OUT_W-1:0] column_index;
        logic [ROM_AW-1:0]    rom_index;
        logic [CODE_W-1:0]    minimum;
    } col_item_t;

    // Shift and subtract quotient, used only while the table is built
    function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Secant scale per distance from the center column, unsigned Q8.10
    function automatic sec_rom_t build_sec_rom();
        sec_rom_t         rom;
        longint unsigned  den;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint unsigned  d;
        longint unsigned  q;
        longint           cosv;
        den = 64'd180 * longint'(COLUMNS);
        for (int m = 0; m < ROM_DEPTH; m++) begin
            x = udiv_u64(longint'(FIELD_OF_VIEW_DEG) * longint'(m) * PI_Q30 + (den >> 1),
                         den);
            if (x > HALF_PI_Q30) begin
                x = HALF_PI_Q30;
            end
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            cosv = longint'(ONE_Q30);
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = udiv_u64(term * x2, longint'(2 * k - 1) * longint'(2 * k));
                if (k[0] == 1'b1) begin
                    cosv = cosv - longint'(term);
                end else begin
                    cosv = cosv + longint'(term);
                end
            end
            if (cosv <= 0) begin
                q = ROM_MAX;
            end else begin
                d = 64'd255 * longint'(cosv);
                q = udiv_u64((SCALE_NUM << 30) + (d >> 1), d);
                if (q > ROM_MAX) begin
                    q = ROM_MAX;
                end
            end
            rom[m] = K_W'(q);
        end
        return rom;
    endfunction

    localparam sec_rom_t SEC_ROM = build_sec_rom();

endpackage

/* design/dcmr_front.sv */
// Pixel front end: running column minimum, column counter, column item issue.
`timescale 1ns / 1ps
module dcmr_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [dcmr_pkg::CODE_W-1:0]    min_valid_code,
    input  logic                           pix_accept,
    input  logic [dcmr_pkg::CODE_W-1:0]    depth_code,
    input  logic                           last_in_column,
    input  logic                           first_of_frame,
    output logic                           push,
    output dcmr_pkg::col_item_t            push_item
);

    logic [dcmr_pkg::CODE_W-1:0] min_reg, min_next;
    logic [dcmr_pkg::COL_W-1:0]  col_reg, col_next;
    logic [dcmr_pkg::CODE_W-1:0] base_min, new_min;
    logic [dcmr_pkg::COL_W-1:0]  base_col, col_inc;
    logic [dcmr_pkg::COL_W-1:0]  half_col;

    always_comb begin
        half_col = dcmr_pkg::COL_W'(dcmr_pkg::HALF_COLUMNS);
        base_min = first_of_frame ? dcmr_pkg::NO_RETURN_CODE : min_reg;
        base_col = first_of_frame ? '0 : col_reg;
        new_min  = (depth_code >= min_valid_code && depth_code < base_min)
                   ? depth_code : base_min;
        col_inc  = (base_col == dcmr_pkg::COL_W'(dcmr_pkg::COLUMNS - 1))
                   ? '0 : base_col + dcmr_pkg::COL_W'(1);

        push                   = pix_accept && last_in_column;
        push_item.column_index = dcmr_pkg::COL_OUT_W'(base_col);
        push_item.minimum      = new_min;
        if (base_col >= half_col) begin
            push_item.rom_index = dcmr_pkg::ROM_AW'(base_col - half_col);
        end else begin
            push_item.rom_index = dcmr_pkg::ROM_AW'(half_col - base_col);
        end

        min_next = min_reg;
        col_next = col_reg;
        if (pix_accept) begin
            if (last_in_column) begin
                min_next = dcmr_pkg::NO_RETURN_CODE;
                col_next = col_inc;
            end else begin
                min_next = new_min;
                col_next = base_col;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= dcmr_pkg::NO_RETURN_CODE;
            col_reg <= '0;
        end else begin
            min_reg <= min_next;
            col_reg <= col_next;
        end
    end

endmodule

/* design/dcmr_queue.sv */
// Short column item queue between the front end and the range pipeline.
`timescale 1ns / 1ps
module dcmr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dcmr_pkg::col_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output dcmr_pkg::col_item_t pop_item
);

    dcmr_pkg::col_item_t               mem_reg [dcmr_pkg::QUEUE_DEPTH];
    logic [dcmr_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dcmr_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dcmr_pkg::QUEUE_AW:0]       count_reg, count_next;
    logic                              do_push, do_pop;

    always_comb begin
        full     = (count_reg == (dcmr_pkg::QUEUE_AW + 1)'(dcmr_pkg::QUEUE_DEPTH));
        empty    = (count_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_item = mem_reg[rd_ptr_reg];

        wr_ptr_next = do_push ? wr_ptr_reg + dcmr_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + dcmr_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (dcmr_pkg::QUEUE_AW + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (dcmr_pkg::QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/dcmr_back.sv */
// Range pipeline: scale lookup, multiply, round and saturate, output register.
`timescale 1ns / 1ps
module dcmr_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  dcmr_pkg::col_item_t              q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dcmr_pkg::COL_OUT_W-1:0]   out_column_index,
    output logic [dcmr_pkg::RANGE_W-1:0]     out_range_mm,
    output logic                             out_no_return
);

    logic                              v1_reg, v2_reg, v3_reg;
    logic                              en1, en2, en3;
    logic [dcmr_pkg::K_W-1:0]          k1_reg;
    logic [dcmr_pkg::CODE_W-1:0]       min1_reg;
    logic [dcmr_pkg::COL_OUT_W-1:0]    col1_reg, col2_reg, col3_reg;
    logic [dcmr_pkg::PROD_W-1:0]       prod2_reg;
    logic                              nr2_reg, nr3_reg;
    logic [dcmr_pkg::RANGE_W-1:0]      range3_reg, range_next;
    logic [dcmr_pkg::PROD_W:0]         rounded;
    logic [dcmr_pkg::PROD_W-dcmr_pkg::FRAC_W:0] scaled;

    always_comb begin
        en3   = !v3_reg || out_ready;
        en2   = !v2_reg || en3;
        en1   = !v1_reg || en2;
        q_pop = en1 && !q_empty;

        rounded = {1'b0, prod2_reg}
                  + (dcmr_pkg::PROD_W + 1)'(1 << (dcmr_pkg::FRAC_W - 1));
        scaled  = rounded[dcmr_pkg::PROD_W:dcmr_pkg::FRAC_W];
        if (scaled > (dcmr_pkg::PROD_W - dcmr_pkg::FRAC_W + 1)'({dcmr_pkg::RANGE_W{1'b1}})) begin
            range_next = '1;
        end else begin
            range_next = dcmr_pkg::RANGE_W'(scaled);
        end

        out_valid        = v3_reg;
        out_column_index = col3_reg;
        out_range_mm     = range3_reg;
        out_no_return    = nr3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            k1_reg   <= dcmr_pkg::SEC_ROM[q_item.rom_index];
            min1_reg <= q_item.minimum;
            col1_reg <= q_item.column_index;
        end
        if (en2) begin
            prod2_reg <= dcmr_pkg::PROD_W'(min1_reg) * dcmr_pkg::PROD_W'(k1_reg);
            nr2_reg   <= (min1_reg == dcmr_pkg::NO_RETURN_CODE);
            col2_reg  <= col1_reg;
        end
        if (en3) begin
            range3_reg <= range_next;
            nr3_reg    <= nr2_reg;
            col3_reg   <= col2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= !q_empty;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

endmodule

/* design/depth_column_min_to_range_top.sv */
// Top level of the depth column ranger: stream ports, register port, front, queue, pipeline.
//
//  channel  | ports            | item
//  ---------+------------------+---------------------------------------------
//  pixels   | s_t*             | tdata: depth_code; tlast: last_in_column;
//           |                  | tuser: first_of_frame
//  ranges   | m_t*             | tdata: column_index, range_mm; tuser: no_return
//  config   | p*               | min_valid_code at byte address 0
//
//  One pixel item per cycle while the queue is not full; the front end updates the
//  column minimum in the cycle the item is taken, so pixel rate is set by that single compare.
//  After its column's last pixel, a range item passes the queue, then the table read,
//  multiply, and round and saturate registers. A four-entry queue takes column items while the
//  result side stalls; s_tready drops only when it is full.
//  Reset is synchronous, active low, and needs no clearing pass.
`timescale 1ns / 1ps
module depth_column_min_to_range_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] depth_code
    input  logic                              s_tlast,
    input  logic                              s_tuser,   // [0] first_of_frame
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [8:0] column_index, [24:9] range_mm
    output logic                              m_tuser,   // [0] no_return
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dcmr_pkg::PADDR_W-1:0]      paddr,
    input  logic [dcmr_pkg::DATA_W-1:0]       pwdata,
    output logic [dcmr_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [dcmr_pkg::CODE_W-1:0]     min_valid_reg;
    logic                            cfg_write;
    logic                            reg_hit;
    logic                            push, q_full, q_empty, q_pop;
    dcmr_pkg::col_item_t             push_item, pop_item;
    logic [dcmr_pkg::COL_OUT_W-1:0]  column_index;
    logic [dcmr_pkg::RANGE_W-1:0]    range_mm;

    always_comb begin
        pready    = 1'b1;
        reg_hit   = (paddr[dcmr_pkg::PADDR_W-1:2] == dcmr_pkg::REG_MIN_VALID_CODE);
        cfg_write = psel && penable && pwrite && pready && reg_hit;
        prdata    = reg_hit ? dcmr_pkg::DATA_W'(min_valid_reg) : '0;
        s_tready  = !q_full;
        m_tdata   = {{(32 - dcmr_pkg::RANGE_W - dcmr_pkg::COL_OUT_W){1'b0}},
                     range_mm, column_index};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_valid_reg <= dcmr_pkg::MIN_VALID_RESET;
        end else if (cfg_write) begin
            min_valid_reg <= pwdata[dcmr_pkg::CODE_W-1:0];
        end
    end

    dcmr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .min_valid_code (min_valid_reg),
        .pix_accept     (s_tvalid && s_tready),
        .depth_code     (s_tdata),
        .last_in_column (s_tlast),
        .first_of_frame (s_tuser),
        .push           (push),
        .push_item      (push_item)
    );

    dcmr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    dcmr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_item           (pop_item),
        .q_pop            (q_pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_column_index (column_index),
        .out_range_mm     (range_mm),
        .out_no_return    (m_tuser)
    );

endmodule
